### src/pvt_pkg.sv
// Shared widths, angle constants, arctangent table and stage payload types.
package pvt_pkg;

    localparam int XY_W   = 33;
    localparam int Z_W    = 34;
    localparam int TRIG_W = 32;
    localparam int MAG_W  = 31;
    localparam int SPD_W  = 32;
    localparam int PROD_W = 62;
    localparam int DEN_W  = 31;
    localparam int OUT_W  = 48;
    localparam int TERM_W = 64;
    localparam int SUM_W  = 65;

    localparam logic signed [Z_W-1:0] ANG_PI      = 34'sd1686629713;
    localparam logic signed [Z_W-1:0] ANG_HALF_PI = 34'sd843314857;
    localparam logic signed [Z_W-1:0] ANG_TWO_PI  = 34'sd3373259426;

    localparam logic signed [XY_W-1:0] GAIN_Q30 = 33'sd652032874;
    localparam logic signed [XY_W-1:0] ONE_Q30  = 33'sd1073741824;

    localparam logic [OUT_W-1:0] SAT_HI = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_LO = {1'b1, {(OUT_W-1){1'b0}}};

    function automatic logic [28:0] atan_q29(input logic [4:0] idx);
        logic [28:0] r;
        case (idx)
            5'd0:    r = 29'd421657428;
            5'd1:    r = 29'd248918915;
            5'd2:    r = 29'd131521918;
            5'd3:    r = 29'd66762579;
            5'd4:    r = 29'd33510843;
            5'd5:    r = 29'd16771758;
            5'd6:    r = 29'd8387925;
            5'd7:    r = 29'd4194219;
            5'd8:    r = 29'd2097141;
            5'd9:    r = 29'd1048575;
            5'd10:   r = 29'd524288;
            5'd11:   r = 29'd262144;
            5'd12:   r = 29'd131072;
            5'd13:   r = 29'd65536;
            5'd14:   r = 29'd32768;
            5'd15:   r = 29'd16384;
            5'd16:   r = 29'd8192;
            5'd17:   r = 29'd4096;
            5'd18:   r = 29'd2048;
            5'd19:   r = 29'd1024;
            5'd20:   r = 29'd512;
            5'd21:   r = 29'd256;
            5'd22:   r = 29'd128;
            5'd23:   r = 29'd64;
            5'd24:   r = 29'd32;
            5'd25:   r = 29'd16;
            5'd26:   r = 29'd8;
            5'd27:   r = 29'd4;
            5'd28:   r = 29'd2;
            5'd29:   r = 29'd1;
            default: r = 29'd0;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic                    neg_lon;
        logic                    neg_lat;
        logic                    pole;
        logic signed [SPD_W-1:0] u;
        logic signed [SPD_W-1:0] v;
    } cside_t;

    typedef struct packed {
        logic neg_a;
        logic neg_b;
        logic neg_c;
        logic neg_d;
        logic zero;
    } d1side_t;

    typedef struct packed {
        logic [PROD_W-1:0] mag_a;
        logic [PROD_W-1:0] mag_c;
        logic              neg_a;
        logic              neg_b;
        logic              neg_c;
        logic              neg_d;
        logic              zero;
        logic              clamp_b;
        logic              clamp_d;
    } d2side_t;

endpackage

### src/pvt_cordic.sv
// Pipelined rotation-mode CORDIC, several angle lanes sharing one pipeline.
module pvt_cordic #(
    parameter int STAGES = 24,
    parameter int LANES  = 2,
    parameter int SIDE_W = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [pvt_pkg::Z_W-1:0]      z_in [LANES],
    input  logic [SIDE_W-1:0]                   side_in,
    output logic                                out_valid,
    output logic signed [pvt_pkg::XY_W-1:0]     x_out [LANES],
    output logic signed [pvt_pkg::XY_W-1:0]     y_out [LANES],
    output logic [SIDE_W-1:0]                   side_out
);

    logic signed [pvt_pkg::XY_W-1:0] x_reg [STAGES][LANES];
    logic signed [pvt_pkg::XY_W-1:0] y_reg [STAGES][LANES];
    logic signed [pvt_pkg::Z_W-1:0]  z_reg [STAGES][LANES];
    logic signed [pvt_pkg::XY_W-1:0] x_src [STAGES][LANES];
    logic signed [pvt_pkg::XY_W-1:0] y_src [STAGES][LANES];
    logic signed [pvt_pkg::Z_W-1:0]  z_src [STAGES][LANES];
    logic signed [pvt_pkg::XY_W-1:0] x_next [STAGES][LANES];
    logic signed [pvt_pkg::XY_W-1:0] y_next [STAGES][LANES];
    logic signed [pvt_pkg::Z_W-1:0]  z_next [STAGES][LANES];
    logic [SIDE_W-1:0]               side_reg [STAGES];
    logic [STAGES-1:0]               vld_reg;

    function automatic logic [pvt_pkg::Z_W-1:0] Z_W_EXT(input logic [28:0] a);
        return {{(pvt_pkg::Z_W-29){1'b0}}, a};
    endfunction

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            x_src[0][l] = pvt_pkg::GAIN_Q30;
            y_src[0][l] = '0;
            z_src[0][l] = z_in[l];
        end
        for (int s = 1; s < STAGES; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                x_src[s][l] = x_reg[s-1][l];
                y_src[s][l] = y_reg[s-1][l];
                z_src[s][l] = z_reg[s-1][l];
            end
        end
    end

    always_comb
    begin
        logic signed [pvt_pkg::XY_W-1:0] dx;
        logic signed [pvt_pkg::XY_W-1:0] dy;
        logic signed [pvt_pkg::Z_W-1:0]  da;
        for (int s = 0; s < STAGES; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                dx = y_src[s][l] >>> s;
                dy = x_src[s][l] >>> s;
                da = signed'(Z_W_EXT(pvt_pkg::atan_q29(5'(s))));
                if (z_src[s][l] >= 0)
                begin
                    x_next[s][l] = x_src[s][l] - dx;
                    y_next[s][l] = y_src[s][l] + dy;
                    z_next[s][l] = z_src[s][l] - da;
                end
                else
                begin
                    x_next[s][l] = x_src[s][l] + dx;
                    y_next[s][l] = y_src[s][l] - dy;
                    z_next[s][l] = z_src[s][l] + da;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                x_reg[s][l] <= x_next[s][l];
                y_reg[s][l] <= y_next[s][l];
                z_reg[s][l] <= z_next[s][l];
            end
        end
        side_reg[0] <= side_in;
        for (int s = 1; s < STAGES; s++)
        begin
            side_reg[s] <= side_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            x_out[l] = x_reg[STAGES-1][l];
            y_out[l] = y_reg[STAGES-1][l];
        end
    end

    assign side_out  = side_reg[STAGES-1];
    assign out_valid = vld_reg[STAGES-1];

endmodule

### src/pvt_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, lanes share the divisor.
module pvt_div_pipe #(
    parameter int LANES  = 4,
    parameter int NUM_W  = 62,
    parameter int SIDE_W = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [pvt_pkg::DEN_W-1:0]     den_in,
    input  logic [pvt_pkg::DEN_W-1:0]     rem_in [LANES],
    input  logic [NUM_W-1:0]              num_in [LANES],
    input  logic [SIDE_W-1:0]             side_in,
    output logic                          out_valid,
    output logic [pvt_pkg::DEN_W-1:0]     den_out,
    output logic [NUM_W-1:0]              quo_out [LANES],
    output logic [SIDE_W-1:0]             side_out
);

    localparam int STEPS = NUM_W;
    localparam int DW    = pvt_pkg::DEN_W;

    logic [DW-1:0]     rem_reg  [STEPS][LANES];
    logic [NUM_W-1:0]  nq_reg   [STEPS][LANES];
    logic [DW-1:0]     den_reg  [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];
    logic [STEPS-1:0]  vld_reg;
    logic [DW-1:0]     rem_src  [STEPS][LANES];
    logic [NUM_W-1:0]  nq_src   [STEPS][LANES];
    logic [DW-1:0]     den_src  [STEPS];
    logic [DW-1:0]     rem_next [STEPS][LANES];
    logic [NUM_W-1:0]  nq_next  [STEPS][LANES];

    always_comb
    begin
        den_src[0] = den_in;
        for (int l = 0; l < LANES; l++)
        begin
            rem_src[0][l] = rem_in[l];
            nq_src[0][l]  = num_in[l];
        end
        for (int s = 1; s < STEPS; s++)
        begin
            den_src[s] = den_reg[s-1];
            for (int l = 0; l < LANES; l++)
            begin
                rem_src[s][l] = rem_reg[s-1][l];
                nq_src[s][l]  = nq_reg[s-1][l];
            end
        end
    end

    always_comb
    begin
        logic [DW:0] t;
        logic [DW:0] d;
        logic [DW:0] diff;
        logic        ge;
        for (int s = 0; s < STEPS; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                t    = {rem_src[s][l], nq_src[s][l][NUM_W-1]};
                d    = {1'b0, den_src[s]};
                diff = t - d;
                ge   = (t >= d);
                rem_next[s][l] = ge ? diff[DW-1:0] : t[DW-1:0];
                nq_next[s][l]  = {nq_src[s][l][NUM_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < STEPS; s++)
        begin
            den_reg[s] <= den_src[s];
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[s][l] <= rem_next[s][l];
                nq_reg[s][l]  <= nq_next[s][l];
            end
        end
        side_reg[0] <= side_in;
        for (int s = 1; s < STEPS; s++)
        begin
            side_reg[s] <= side_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STEPS-2:0], in_valid};
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quo_out[l] = nq_reg[STEPS-1][l];
        end
    end

    assign den_out   = den_reg[STEPS-1];
    assign side_out  = side_reg[STEPS-1];
    assign out_valid = vld_reg[STEPS-1];

endmodule

### src/polar_velocity_transform.sv
// Top level: polar stereographic velocity transform, fully pipelined.
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------------------
//  input    | start, busy      | lon_angle, lat_angle, pole_select, east_speed,
//           |                  | north_speed
//  result   | done (strobe)    | proj_x_speed, proj_y_speed, range_fault
//
// One item per cycle; busy stays low. The pipeline runs through fold,
// CORDIC_STAGES CORDIC stages, clamp, magnitude, multiply, two 62-stage
// divider pipelines, term, sum and saturate stages.
// Reset clears only the valid bits. The result receiver cannot stall, so
// nothing is held back.
module polar_velocity_transform #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [31:0]                         lon_angle,
    input  logic signed [30:0]                  lat_angle,
    input  logic                                pole_select,
    input  logic signed [31:0]                  east_speed,
    input  logic signed [31:0]                  north_speed,
    output logic                                done,
    output logic signed [pvt_pkg::OUT_W-1:0]    proj_x_speed,
    output logic signed [pvt_pkg::OUT_W-1:0]    proj_y_speed,
    output logic                                range_fault
);

    localparam int ZW = pvt_pkg::Z_W;
    localparam int XW = pvt_pkg::XY_W;
    localparam int TW = pvt_pkg::TRIG_W;
    localparam int MW = pvt_pkg::MAG_W;
    localparam int SW = pvt_pkg::SPD_W;
    localparam int PW = pvt_pkg::PROD_W;
    localparam int DW = pvt_pkg::DEN_W;
    localparam int OW = pvt_pkg::OUT_W;
    localparam int EW = pvt_pkg::TERM_W;
    localparam int UW = pvt_pkg::SUM_W;

    function automatic logic [ZW:0] fold(input logic signed [ZW-1:0] ang);
        logic signed [ZW-1:0] a;
        logic                 neg;
        a   = ang;
        neg = 1'b0;
        if (a > pvt_pkg::ANG_HALF_PI)
        begin
            a   = a - pvt_pkg::ANG_PI;
            neg = 1'b1;
        end
        else if (a < -pvt_pkg::ANG_HALF_PI)
        begin
            a   = a + pvt_pkg::ANG_PI;
            neg = 1'b1;
        end
        return {neg, a};
    endfunction

    function automatic logic signed [TW-1:0] clamp_trig(input logic signed [XW-1:0] v,
                                                         input logic neg);
        logic signed [XW-1:0] c;
        if (v > pvt_pkg::ONE_Q30)
            c = pvt_pkg::ONE_Q30;
        else if (v < -pvt_pkg::ONE_Q30)
            c = -pvt_pkg::ONE_Q30;
        else
            c = v;
        c = neg ? -c : c;
        return c[TW-1:0];
    endfunction

    function automatic logic [MW-1:0] mag_trig(input logic signed [TW-1:0] v);
        logic signed [TW-1:0] a;
        a = (v < 0) ? -v : v;
        return a[MW-1:0];
    endfunction

    function automatic logic [SW-1:0] mag_spd(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] a;
        a = (v < 0) ? -v : v;
        return a;
    endfunction

    function automatic logic signed [EW-1:0] signed_term(input logic [EW-2:0] m,
                                                          input logic neg);
        logic signed [EW-1:0] w;
        w = signed'({1'b0, m});
        return neg ? -w : w;
    endfunction

    // fold stage
    logic                 s0_vld_reg;
    logic signed [ZW-1:0] s0_zlon_reg;
    logic signed [ZW-1:0] s0_zlat_reg;
    pvt_pkg::cside_t      s0_side_reg;
    logic signed [ZW-1:0] lon_w;
    logic signed [ZW-1:0] lon_next;
    logic [ZW:0]          lon_fold;
    logic [ZW:0]          lat_fold;
    logic                 accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        lon_w    = signed'({2'b00, lon_angle});
        lon_next = (lon_w > pvt_pkg::ANG_PI) ? lon_w - pvt_pkg::ANG_TWO_PI : lon_w;
        lon_fold = fold(lon_next);
        lat_fold = fold(ZW'(lat_angle));
    end

    always_ff @(posedge clk)
    begin
        s0_zlon_reg         <= lon_fold[ZW-1:0];
        s0_zlat_reg         <= lat_fold[ZW-1:0];
        s0_side_reg.neg_lon <= lon_fold[ZW];
        s0_side_reg.neg_lat <= lat_fold[ZW];
        s0_side_reg.pole    <= pole_select;
        s0_side_reg.u       <= east_speed;
        s0_side_reg.v       <= north_speed;
    end

    // CORDIC
    logic signed [ZW-1:0]      cor_z [2];
    logic signed [XW-1:0]      cor_x [2];
    logic signed [XW-1:0]      cor_y [2];
    logic                      cor_vld;
    logic [$bits(pvt_pkg::cside_t)-1:0] cor_side_raw;
    pvt_pkg::cside_t           cor_side;

    assign cor_z[0] = s0_zlon_reg;
    assign cor_z[1] = s0_zlat_reg;
    assign cor_side = pvt_pkg::cside_t'(cor_side_raw);

    pvt_cordic #(
        .STAGES (CORDIC_STAGES),
        .LANES  (2),
        .SIDE_W ($bits(pvt_pkg::cside_t))
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_vld_reg),
        .z_in      (cor_z),
        .side_in   (s0_side_reg),
        .out_valid (cor_vld),
        .x_out     (cor_x),
        .y_out     (cor_y),
        .side_out  (cor_side_raw)
    );

    // clamp stage
    logic                 s1_vld_reg;
    logic signed [TW-1:0] s1_sin_lon_reg;
    logic signed [TW-1:0] s1_cos_lon_reg;
    logic signed [TW-1:0] s1_sin_lat_reg;
    logic signed [SW-1:0] s1_u_reg;
    logic signed [SW-1:0] s1_v_reg;
    logic                 s1_pole_reg;

    always_ff @(posedge clk)
    begin
        s1_sin_lon_reg <= clamp_trig(cor_y[0], cor_side.neg_lon);
        s1_cos_lon_reg <= clamp_trig(cor_x[0], cor_side.neg_lon);
        s1_sin_lat_reg <= clamp_trig(cor_y[1], cor_side.neg_lat);
        s1_u_reg       <= cor_side.u;
        s1_v_reg       <= cor_side.v;
        s1_pole_reg    <= cor_side.pole;
    end

    // magnitude stage
    logic            s2_vld_reg;
    logic [MW-1:0]   s2_ms_lon_reg;
    logic [MW-1:0]   s2_mc_lon_reg;
    logic [MW-1:0]   s2_m_lat_reg;
    logic [SW-1:0]   s2_mu_reg;
    logic [SW-1:0]   s2_mv_reg;
    pvt_pkg::d1side_t s2_side_reg;
    logic            sg_sl;
    logic            sg_cl;
    logic            sg_lat;
    logic            sg_u;
    logic            sg_v;

    always_comb
    begin
        sg_sl  = s1_sin_lon_reg[TW-1];
        sg_cl  = s1_cos_lon_reg[TW-1];
        sg_lat = s1_sin_lat_reg[TW-1];
        sg_u   = s1_u_reg[SW-1];
        sg_v   = s1_v_reg[SW-1];
    end

    always_ff @(posedge clk)
    begin
        s2_ms_lon_reg     <= mag_trig(s1_sin_lon_reg);
        s2_mc_lon_reg     <= mag_trig(s1_cos_lon_reg);
        s2_m_lat_reg      <= mag_trig(s1_sin_lat_reg);
        s2_mu_reg         <= mag_spd(s1_u_reg);
        s2_mv_reg         <= mag_spd(s1_v_reg);
        s2_side_reg.neg_a <= sg_sl ^ sg_u ^ sg_lat ^ ~s1_pole_reg;
        s2_side_reg.neg_b <= sg_cl ^ sg_v ^ ~s1_pole_reg;
        s2_side_reg.neg_c <= sg_cl ^ sg_u ^ sg_lat ^ s1_pole_reg;
        s2_side_reg.neg_d <= sg_sl ^ sg_v ^ ~s1_pole_reg;
        s2_side_reg.zero  <= (s1_sin_lat_reg == '0);
    end

    // multiply stage
    logic             s3_vld_reg;
    logic [PW-1:0]    s3_prod_reg [4];
    logic [DW-1:0]    s3_den_reg;
    pvt_pkg::d1side_t s3_side_reg;
    logic [PW:0]      prod_w [4];

    always_comb
    begin
        prod_w[0] = (PW+1)'(s2_ms_lon_reg) * (PW+1)'(s2_mu_reg);
        prod_w[1] = (PW+1)'(s2_mc_lon_reg) * (PW+1)'(s2_mu_reg);
        prod_w[2] = (PW+1)'(s2_mc_lon_reg) * (PW+1)'(s2_mv_reg);
        prod_w[3] = (PW+1)'(s2_ms_lon_reg) * (PW+1)'(s2_mv_reg);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            s3_prod_reg[k] <= prod_w[k][PW-1:0];
        end
        s3_den_reg  <= s2_m_lat_reg;
        s3_side_reg <= s2_side_reg;
    end

    // first division: A, C final; B, D first step
    logic [DW-1:0]    d1_rem_in [4];
    logic [PW-1:0]    d1_quo [4];
    logic [DW-1:0]    d1_den;
    logic             d1_vld;
    logic [$bits(pvt_pkg::d1side_t)-1:0] d1_side_raw;
    pvt_pkg::d1side_t d1_side;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            d1_rem_in[k] = '0;
        end
    end

    assign d1_side = pvt_pkg::d1side_t'(d1_side_raw);

    pvt_div_pipe #(
        .LANES  (4),
        .NUM_W  (PW),
        .SIDE_W ($bits(pvt_pkg::d1side_t))
    ) u_div_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_vld_reg),
        .den_in    (s3_den_reg),
        .rem_in    (d1_rem_in),
        .num_in    (s3_prod_reg),
        .side_in   (s3_side_reg),
        .out_valid (d1_vld),
        .den_out   (d1_den),
        .quo_out   (d1_quo),
        .side_out  (d1_side_raw)
    );

    // second division of B and D by the latitude sine, scaled by 2^30
    logic [DW-1:0]    d2_rem_in [2];
    logic [PW-1:0]    d2_num_in [2];
    pvt_pkg::d2side_t d2_side_in;
    logic [PW-1:0]    d2_quo [2];
    logic [DW-1:0]    d2_den;
    logic             d2_vld;
    logic [$bits(pvt_pkg::d2side_t)-1:0] d2_side_raw;
    pvt_pkg::d2side_t d2_side;

    always_comb
    begin
        d2_num_in[0]       = {d1_quo[2][31:0], 30'b0};
        d2_num_in[1]       = {d1_quo[3][31:0], 30'b0};
        d2_rem_in[0]       = {1'b0, d1_quo[2][PW-1:32]};
        d2_rem_in[1]       = {1'b0, d1_quo[3][PW-1:32]};
        d2_side_in.mag_a   = d1_quo[0];
        d2_side_in.mag_c   = d1_quo[1];
        d2_side_in.neg_a   = d1_side.neg_a;
        d2_side_in.neg_b   = d1_side.neg_b;
        d2_side_in.neg_c   = d1_side.neg_c;
        d2_side_in.neg_d   = d1_side.neg_d;
        d2_side_in.zero    = d1_side.zero;
        d2_side_in.clamp_b = ({1'b0, d1_quo[2][PW-1:32]} >= d1_den);
        d2_side_in.clamp_d = ({1'b0, d1_quo[3][PW-1:32]} >= d1_den);
    end

    assign d2_side = pvt_pkg::d2side_t'(d2_side_raw);

    pvt_div_pipe #(
        .LANES  (2),
        .NUM_W  (PW),
        .SIDE_W ($bits(pvt_pkg::d2side_t))
    ) u_div_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_vld),
        .den_in    (d1_den),
        .rem_in    (d2_rem_in),
        .num_in    (d2_num_in),
        .side_in   (d2_side_in),
        .out_valid (d2_vld),
        .den_out   (d2_den),
        .quo_out   (d2_quo),
        .side_out  (d2_side_raw)
    );

    // term stage
    logic                 f1_vld_reg;
    logic signed [EW-1:0] f1_term_reg [4];
    logic                 f1_zero_reg;
    logic [EW-2:0]        mag_b;
    logic [EW-2:0]        mag_d;

    always_comb
    begin
        mag_b = d2_side.clamp_b ? {1'b1, {(EW-2){1'b0}}} : {1'b0, d2_quo[0]};
        mag_d = d2_side.clamp_d ? {1'b1, {(EW-2){1'b0}}} : {1'b0, d2_quo[1]};
    end

    always_ff @(posedge clk)
    begin
        f1_term_reg[0] <= signed_term({1'b0, d2_side.mag_a}, d2_side.neg_a);
        f1_term_reg[1] <= signed_term(mag_b, d2_side.neg_b);
        f1_term_reg[2] <= signed_term({1'b0, d2_side.mag_c}, d2_side.neg_c);
        f1_term_reg[3] <= signed_term(mag_d, d2_side.neg_d);
        f1_zero_reg    <= d2_side.zero || (d2_den == '0);
    end

    // sum stage
    logic                 f2_vld_reg;
    logic signed [UW-1:0] f2_ut_reg;
    logic signed [UW-1:0] f2_vt_reg;
    logic                 f2_zero_reg;

    always_ff @(posedge clk)
    begin
        f2_ut_reg   <= UW'(f1_term_reg[0]) + UW'(f1_term_reg[1]);
        f2_vt_reg   <= UW'(f1_term_reg[2]) + UW'(f1_term_reg[3]);
        f2_zero_reg <= f1_zero_reg;
    end

    // saturate stage
    logic                 done_reg;
    logic signed [OW-1:0] x_reg;
    logic signed [OW-1:0] y_reg;
    logic                 fault_reg;
    logic                 fit_x;
    logic                 fit_y;
    logic signed [OW-1:0] x_next;
    logic signed [OW-1:0] y_next;
    logic                 fault_next;

    always_comb
    begin
        fit_x = (f2_ut_reg[UW-1:OW-1] == {(UW-OW+1){f2_ut_reg[UW-1]}});
        fit_y = (f2_vt_reg[UW-1:OW-1] == {(UW-OW+1){f2_vt_reg[UW-1]}});
        x_next = fit_x ? f2_ut_reg[OW-1:0]
                       : (f2_ut_reg[UW-1] ? pvt_pkg::SAT_LO : pvt_pkg::SAT_HI);
        y_next = fit_y ? f2_vt_reg[OW-1:0]
                       : (f2_vt_reg[UW-1] ? pvt_pkg::SAT_LO : pvt_pkg::SAT_HI);
        fault_next = !fit_x || !fit_y;
        if (f2_zero_reg)
        begin
            x_next     = '0;
            y_next     = '0;
            fault_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        fault_reg <= fault_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= accept;
            s1_vld_reg <= cor_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            f1_vld_reg <= d2_vld;
            f2_vld_reg <= f1_vld_reg;
            done_reg   <= f2_vld_reg;
        end
    end

    assign done         = done_reg;
    assign proj_x_speed = x_reg;
    assign proj_y_speed = y_reg;
    assign range_fault  = fault_reg;

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        f2_vld_reg && f2_zero_reg |=> done && range_fault
            && proj_x_speed == '0 && proj_y_speed == '0)
        else $error("zero latitude sine did not give a zeroed, flagged item");

    a_fault_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done && range_fault |-> (proj_x_speed == '0 && proj_y_speed == '0)
            || proj_x_speed == pvt_pkg::SAT_HI || proj_x_speed == pvt_pkg::SAT_LO
            || proj_y_speed == pvt_pkg::SAT_HI || proj_y_speed == pvt_pkg::SAT_LO)
        else $error("fault raised without saturation or zero sine");

    a_sin_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg |-> XW'(s1_sin_lat_reg) <= pvt_pkg::ONE_Q30
            && XW'(s1_sin_lat_reg) >= -pvt_pkg::ONE_Q30)
        else $error("latitude sine outside unit range");

    a_tail_flow: assert property (@(posedge clk) disable iff (!rst_n)
        f1_vld_reg |=> ##1 done)
        else $error("item lost in output stages");

endmodule

### bench/polar_velocity_transform_checker.sv
// Result checker for the polar velocity transform: predicts and compares every item.
module polar_velocity_transform_checker #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [31:0]                         lon_angle,
    input  logic signed [30:0]                  lat_angle,
    input  logic                                pole_select,
    input  logic signed [31:0]                  east_speed,
    input  logic signed [31:0]                  north_speed,
    input  logic                                done,
    input  logic signed [pvt_pkg::OUT_W-1:0]    proj_x_speed,
    input  logic signed [pvt_pkg::OUT_W-1:0]    proj_y_speed,
    input  logic                                range_fault,
    output int                                  fail_count,
    output int                                  pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [pvt_pkg::OUT_W-1:0] x_speed;
        logic signed [pvt_pkg::OUT_W-1:0] y_speed;
        logic                             fault;
    } velocity_t;

    localparam longint PI_Q29      = 64'sd1686629713;
    localparam longint HALF_PI_Q29 = 64'sd843314857;
    localparam longint TWO_PI_Q29  = 64'sd3373259426;
    localparam longint GAIN        = 64'sd652032874;
    localparam longint UNIT_Q30    = 64'sd1073741824;
    localparam longint MAX_OUT     = 64'sd140737488355327;
    localparam longint MIN_OUT     = -64'sd140737488355328;
    localparam longint HELD_TERM   = 64'sd4611686018427387904;
    localparam longint QUOT_LIMIT  = 64'sd4294967296;

    velocity_t expected_velocities[$];

    function automatic longint arc_step(int i);
        longint t[32] = '{421657428, 248918915, 131521918, 66762579, 33510843,
                          16771758, 8387925, 4194219, 2097141, 1048575, 524288,
                          262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048,
                          1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0};
        return t[i & 31];
    endfunction

    function automatic void rotate_angle(input longint angle, output longint sn,
                                         output longint cs);
        logic   flip;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        flip = 1'b0;
        x = GAIN;
        y = 0;
        if (angle > PI_Q29)
            angle -= TWO_PI_Q29;
        if (angle > HALF_PI_Q29)
        begin
            angle -= PI_Q29;
            flip = 1'b1;
        end
        else if (angle < -HALF_PI_Q29)
        begin
            angle += PI_Q29;
            flip = 1'b1;
        end
        z = angle;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arc_step(i);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arc_step(i);
            end
        end
        if (x > UNIT_Q30) x = UNIT_Q30;
        if (x < -UNIT_Q30) x = -UNIT_Q30;
        if (y > UNIT_Q30) y = UNIT_Q30;
        if (y < -UNIT_Q30) y = -UNIT_Q30;
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    function automatic longint rescale_by_sine(longint a, longint d);
        longint q;
        longint r;
        q = a / d;
        r = a % d;
        if (q >= QUOT_LIMIT)
            return HELD_TERM;
        if (q <= -QUOT_LIMIT)
            return -HELD_TERM;
        return q * UNIT_Q30 + (r * UNIT_Q30) / d;
    endfunction

    function automatic velocity_t project_velocity(logic [31:0] lon, logic signed [30:0] lat,
                                                   logic south, logic signed [31:0] u_in,
                                                   logic signed [31:0] v_in);
        velocity_t res;
        longint    s_lon;
        longint    c_lon;
        longint    s_lat;
        longint    c_lat;
        longint    u;
        longint    v;
        longint    ta;
        longint    tb;
        longint    tc;
        longint    td;
        longint    ut;
        longint    vt;
        u = u_in;
        v = v_in;
        rotate_angle(longint'({32'd0, lon}), s_lon, c_lon);
        rotate_angle(longint'(lat), s_lat, c_lat);
        res.fault = 1'b0;
        if (s_lat == 0)
        begin
            res.x_speed = '0;
            res.y_speed = '0;
            res.fault = 1'b1;
            return res;
        end
        ta = (s_lon * u) / s_lat;
        tb = rescale_by_sine((c_lon * v) / s_lat, s_lat);
        tc = (c_lon * u) / s_lat;
        td = rescale_by_sine((s_lon * v) / s_lat, s_lat);
        ut = -ta - tb;
        vt = tc - td;
        if (south)
        begin
            ut = -ut;
            vt = -vt;
        end
        if (ut > MAX_OUT) begin ut = MAX_OUT; res.fault = 1'b1; end
        if (ut < MIN_OUT) begin ut = MIN_OUT; res.fault = 1'b1; end
        if (vt > MAX_OUT) begin vt = MAX_OUT; res.fault = 1'b1; end
        if (vt < MIN_OUT) begin vt = MIN_OUT; res.fault = 1'b1; end
        res.x_speed = ut[pvt_pkg::OUT_W-1:0];
        res.y_speed = vt[pvt_pkg::OUT_W-1:0];
        return res;
    endfunction

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
    end

    always @(posedge clk)
    begin
        velocity_t want;
        if (rst_n)
        begin
            if (start && !busy)
                expected_velocities.push_back(project_velocity(lon_angle, lat_angle,
                                              pole_select, east_speed, north_speed));
            if (done)
            begin
                if (expected_velocities.size() == 0)
                begin
                    $error("unexpected result x=%0d y=%0d fault=%0b",
                           proj_x_speed, proj_y_speed, range_fault);
                    fail_count++;
                end
                else
                begin
                    want = expected_velocities.pop_front();
                    if (proj_x_speed !== want.x_speed)
                    begin
                        $error("proj_x_speed expected %0d actual %0d",
                               want.x_speed, proj_x_speed);
                        fail_count++;
                    end
                    if (proj_y_speed !== want.y_speed)
                    begin
                        $error("proj_y_speed expected %0d actual %0d",
                               want.y_speed, proj_y_speed);
                        fail_count++;
                    end
                    if (range_fault !== want.fault)
                    begin
                        $error("range_fault expected %0b actual %0b",
                               want.fault, range_fault);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = expected_velocities.size();
    end
endmodule

### bench/polar_velocity_transform_tb.sv
// Testbench top: drives items into the polar velocity transform and gives the verdict.
module polar_velocity_transform_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES      = 24;
    localparam int LATENCY     = STAGES + 131;
    localparam int STALL_LIMIT = 10 * LATENCY + 100;
    localparam int RANDOM_ITEMS = 1850;
    localparam logic [31:0] LON_MAX = 32'd3373259426;
    localparam int          LAT_MAX = 843314857;

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic [31:0]                       lon_angle;
    logic signed [30:0]                lat_angle;
    logic                              pole_select;
    logic signed [31:0]                east_speed;
    logic signed [31:0]                north_speed;
    logic                              done;
    logic signed [pvt_pkg::OUT_W-1:0]  proj_x_speed;
    logic signed [pvt_pkg::OUT_W-1:0]  proj_y_speed;
    logic                              range_fault;
    int                                fail_count;
    int                                pending_count;
    int                                idle_cycles;

    polar_velocity_transform #(.CORDIC_STAGES(STAGES)) i_dut (.*);

    polar_velocity_transform_checker #(.CORDIC_STAGES(STAGES)) i_checker (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[polar_velocity_transform] ERROR");
            $finish;
        end
    end

    task automatic send_item(logic [31:0] lon, logic signed [30:0] lat, logic pole,
                             logic signed [31:0] u, logic signed [31:0] v);
        int gap;
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        start       <= 1'b1;
        lon_angle   <= lon;
        lat_angle   <= lat;
        pole_select <= pole;
        east_speed  <= u;
        north_speed <= v;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic logic signed [31:0] random_speed();
        case ($urandom_range(0, 3))
            0:       return $signed($urandom_range(0, 65535 * 16)) - 32'sd524288;
            1:       return $signed($urandom());
            2:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(0, 2000)) - 32'sd1000;
        endcase
    endfunction

    function automatic logic signed [30:0] random_lat();
        case ($urandom_range(0, 4))
            0:       return 31'($signed($urandom_range(0, 64)) - 32);
            1:       return 31'($urandom());
            default: return 31'($signed($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
        endcase
    endfunction

    function automatic logic [31:0] random_lon();
        if ($urandom_range(0, 4) == 0)
            return $urandom();
        return $urandom_range(0, LON_MAX);
    endfunction

    initial
    begin
        idle_cycles = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        lon_angle   = '0;
        lat_angle   = '0;
        pole_select = 1'b0;
        east_speed  = '0;
        north_speed = '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(32'd0, 31'sd0, 1'b0, 32'sd65536, 32'sd65536);
        send_item(32'd0, 31'sd16, 1'b1, 32'sd65536, -32'sd65536);
        send_item(LON_MAX, 31'sd843314857, 1'b0, 32'sh7FFFFFFF, 32'sh80000000);
        send_item(LON_MAX, -31'sd843314857, 1'b1, 32'sh80000000, 32'sh7FFFFFFF);
        send_item(32'd1686629713, 31'sd1, 1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_item(32'd843314857, -31'sd1, 1'b1, 32'sh80000000, 32'sh80000000);
        send_item(32'hFFFFFFFF, 31'sh3FFFFFFF, 1'b0, 32'sd1000, -32'sd1000);
        send_item(32'd2529944569, 31'sh40000000, 1'b1, -32'sd1, 32'sd1);
        send_item(32'd421657428, 31'sd421657428, 1'b0, 32'sd0, 32'sd0);
        send_item(32'd100, 31'sd1000, 1'b1, 32'sd12345678, -32'sd7654321);
        send_item(32'hAAAAAAAA, 31'sh55555555, 1'b0, 32'sh55555555, 32'shAAAAAAAA);
        send_item(32'h55555555, 31'sh2AAAAAAA, 1'b1, 32'shAAAAAAAA, 32'sh55555555);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                start <= 1'b0;
                @(posedge clk);
                wait (pending_count == 0);
            end
            send_item(random_lon(), random_lat(), 1'($urandom_range(0, 1)),
                      random_speed(), random_speed());
        end

        start <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
        repeat (LATENCY + 10)
            @(posedge clk);
        if (fail_count == 0)
            $display("[polar_velocity_transform] OK");
        else
            $display("[polar_velocity_transform] ERROR");
        $finish;
    end
endmodule
